>>> rtl/amdc_pkg.sv
// Shared types, codes and constants of the aux memory DMA controller.
package amdc_pkg;

	// Field widths
	localparam int ADDR_W  = 26;
	localparam int LEN_W   = 28;
	localparam int DATA_W  = 32;
	localparam int SEL_W   = 4;
	localparam int REQ_W   = 2;
	localparam int KIND_W  = 3;
	localparam int TICK_W  = 16;
	localparam int SIZE_W  = 16;

	// Memory geometry
	localparam longint AUX_BYTES   = 64'd16777216;
	localparam int     BURST_BYTES = 32;
	localparam logic [ADDR_W-1:0] BOOT_MAIN = 26'h100_0000;

	// Depth of the queues between front, back and the result side
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Request types
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// Register selectors
	localparam logic [SEL_W-1:0] SEL_MAIN_HI  = 4'd0;
	localparam logic [SEL_W-1:0] SEL_MAIN_LO  = 4'd1;
	localparam logic [SEL_W-1:0] SEL_AUX_HI   = 4'd2;
	localparam logic [SEL_W-1:0] SEL_AUX_LO   = 4'd3;
	localparam logic [SEL_W-1:0] SEL_COUNT_HI = 4'd4;
	localparam logic [SEL_W-1:0] SEL_COUNT_LO = 4'd5;
	localparam logic [SEL_W-1:0] SEL_MAIN_W   = 4'd6;
	localparam logic [SEL_W-1:0] SEL_AUX_W    = 4'd7;
	localparam logic [SEL_W-1:0] SEL_COUNT_W  = 4'd8;
	localparam logic [SEL_W-1:0] SEL_SIZE     = 4'd9;
	localparam logic [SEL_W-1:0] SEL_MODE     = 4'd10;
	localparam logic [SEL_W-1:0] SEL_REFRESH  = 4'd11;

	// Transfer command kinds
	localparam logic [KIND_W-1:0] XK_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] XK_M2A   = 3'd1;
	localparam logic [KIND_W-1:0] XK_A2M   = 3'd2;
	localparam logic [KIND_W-1:0] XK_ZFILL = 3'd3;
	localparam logic [KIND_W-1:0] XK_BOOT  = 3'd4;

	// Configuration register indexes
	localparam logic CFG_INT_MASK    = 1'b0;
	localparam logic CFG_SLICE_TICKS = 1'b1;

	// Input word
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SEL_W-1:0]  reg_sel;
		logic [DATA_W-1:0] wdata;
	} in_item_t;

	// Result word
	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic [KIND_W-1:0] xfer_kind;
		logic [ADDR_W-1:0] xfer_main_addr;
		logic [ADDR_W-1:0] xfer_aram_addr;
		logic [LEN_W-1:0]  xfer_len;
		logic              busy_res;
		logic              int_flag;
		logic              irq;
	} result_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic              tick;
		logic              clr;
		logic              start;
		logic [SEL_W-1:0]  sel;
		logic [DATA_W-1:0] wdata;
	} cmd_t;

endpackage

>>> rtl/amdc_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module amdc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  amdc_pkg::in_item_t req,
	input  logic              take,
	output logic              cmd_valid,
	output amdc_pkg::cmd_t    cmd
);
	import amdc_pkg::*;

	cmd_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cls;
	logic              do_push;
	logic              do_pop;

	// Classify the incoming word
	always_comb begin
		cls.wr    = (req.req_type == REQ_WRITE);
		cls.rd    = (req.req_type == REQ_READ);
		cls.tick  = (req.req_type == REQ_TICK);
		cls.clr   = (req.req_type == REQ_CLEAR);
		cls.start = (req.req_type == REQ_WRITE) &&
			((req.reg_sel == SEL_COUNT_LO) || (req.reg_sel == SEL_COUNT_W));
		cls.sel   = req.reg_sel;
		cls.wdata = req.wdata;
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign do_pop    = take && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	// Store the classified word
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_front_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("front queue over depth");
	a_front_pop: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("front queue lost a word");

endmodule

>>> rtl/amdc_back.sv
// Back end: holds DMA state and configuration, executes one request word per cycle unless the result queue is full.
module amdc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [15:0]          cfg_wdata,
	input  logic                 cmd_valid,
	input  amdc_pkg::cmd_t       cmd,
	output logic                 take,
	input  logic                 res_full,
	output logic                 res_push,
	output amdc_pkg::result_t    res_in
);
	import amdc_pkg::*;

	localparam logic [ADDR_W:0]   AUX_LIMIT = (ADDR_W + 1)'(AUX_BYTES);
	localparam logic [ADDR_W-1:0] BURST_A   = ADDR_W'(BURST_BYTES);

	logic              int_mask_q;
	logic [TICK_W-1:0] slice_ticks_q;
	logic [ADDR_W-1:0] main_q, aux_q, cnt_q;
	logic              dir_q, busy_q, pend_q;
	logic [SIZE_W-1:0] size_q;
	logic [TICK_W-1:0] slice_q;

	logic [ADDR_W-1:0] main_d, aux_d, cnt_d;
	logic              dir_d, busy_d, pend_d;
	logic [SIZE_W-1:0] size_d;
	logic [TICK_W-1:0] slice_d;
	logic [TICK_W-1:0] ticks_eff;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] xm, xa;
	logic [LEN_W-1:0]  xl;
	logic [DATA_W-1:0] rd;

	assign take      = cmd_valid && !res_full;
	assign res_push  = take;
	assign ticks_eff = (slice_ticks_q == '0) ? TICK_W'(1) : slice_ticks_q;

	// Execute one request against the current state
	always_comb begin
		main_d  = main_q;
		aux_d   = aux_q;
		cnt_d   = cnt_q;
		dir_d   = dir_q;
		busy_d  = busy_q;
		pend_d  = pend_q;
		size_d  = size_q;
		slice_d = slice_q;
		kind    = XK_NONE;
		xm      = '0;
		xa      = '0;
		xl      = '0;
		rd      = '0;

		// register writes
		if (cmd.wr) begin
			unique case (cmd.sel)
				SEL_MAIN_HI:  main_d[25:16] = cmd.wdata[9:0];
				SEL_MAIN_LO:  main_d[15:5]  = cmd.wdata[15:5];
				SEL_AUX_HI:   aux_d[25:16]  = cmd.wdata[9:0];
				SEL_AUX_LO:   aux_d[15:5]   = cmd.wdata[15:5];
				SEL_COUNT_HI: begin
					dir_d         = cmd.wdata[15];
					cnt_d[25:16]  = cmd.wdata[9:0];
				end
				SEL_COUNT_LO: cnt_d[15:5]   = cmd.wdata[15:5];
				SEL_MAIN_W:   main_d = {cmd.wdata[25:5], 5'b0};
				SEL_AUX_W:    aux_d  = {cmd.wdata[25:5], 5'b0};
				SEL_COUNT_W: begin
					dir_d = cmd.wdata[31];
					cnt_d = {cmd.wdata[25:5], 5'b0};
				end
				SEL_SIZE:     size_d = cmd.wdata[15:0];
				default:      ;
			endcase
		end

		// start a transfer on a count write while idle
		if (cmd.start && !busy_q) begin
			priority if ((main_d == BOOT_MAIN) && (aux_d == '0)) begin
				kind   = XK_BOOT;
				xm     = main_d;
				xl     = {cnt_d, 2'b00};
				cnt_d  = '0;
				pend_d = 1'b1;
			end else if ({1'b0, aux_d} >= AUX_LIMIT) begin
				if (dir_d) begin
					kind   = XK_ZFILL;
					xm     = main_d;
					xa     = aux_d;
					xl     = {2'b00, cnt_d};
					cnt_d  = '0;
					pend_d = 1'b1;
				end
			end else if (cnt_d == '0) begin
				pend_d = 1'b1;
			end else begin
				busy_d  = 1'b1;
				slice_d = ticks_eff;
			end
		end

		// tick: count down the slice, issue a burst when it runs out
		if (cmd.tick && busy_q) begin
			if (slice_q > TICK_W'(1)) begin
				slice_d = slice_q - 1'b1;
			end else begin
				slice_d = ticks_eff;
				if (cnt_q != '0) begin
					kind   = dir_q ? XK_A2M : XK_M2A;
					xm     = main_q;
					xa     = aux_q;
					xl     = LEN_W'(BURST_BYTES);
					main_d = main_q + BURST_A;
					aux_d  = aux_q + BURST_A;
					cnt_d  = cnt_q - BURST_A;
				end
				if (cnt_d == '0) begin
					busy_d = 1'b0;
					pend_d = 1'b1;
				end
			end
		end

		// drop the interrupt flag
		if (cmd.clr) begin
			pend_d = 1'b0;
		end

		// register reads
		if (cmd.rd) begin
			unique case (cmd.sel)
				SEL_MAIN_HI:  rd = {22'b0, main_q[25:16]};
				SEL_MAIN_LO:  rd = {16'b0, main_q[15:5], 5'b0};
				SEL_AUX_HI:   rd = {22'b0, aux_q[25:16]};
				SEL_AUX_LO:   rd = {16'b0, aux_q[15:5], 5'b0};
				SEL_COUNT_HI: rd = {16'b0, dir_q, 5'b0, cnt_q[25:16]};
				SEL_COUNT_LO: rd = {16'b0, cnt_q[15:5], 5'b0};
				SEL_MAIN_W:   rd = {6'b0, main_q};
				SEL_AUX_W:    rd = {6'b0, aux_q};
				SEL_COUNT_W:  rd = {dir_q, 5'b0, cnt_q};
				SEL_SIZE:     rd = {16'b0, size_q};
				SEL_MODE:     rd = DATA_W'(1);
				default:      rd = '0;
			endcase
		end
	end

	// Assemble the result word
	always_comb begin
		res_in.rdata          = rd;
		res_in.xfer_kind      = kind;
		res_in.xfer_main_addr = xm;
		res_in.xfer_aram_addr = xa;
		res_in.xfer_len       = xl;
		res_in.busy_res       = busy_d;
		res_in.int_flag       = pend_d;
		res_in.irq            = pend_d & int_mask_q;
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_mask_q    <= 1'b0;
			slice_ticks_q <= TICK_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_INT_MASK:    int_mask_q    <= cfg_wdata[0];
				CFG_SLICE_TICKS: slice_ticks_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Commit state for each executed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q  <= '0;
			aux_q   <= '0;
			cnt_q   <= '0;
			dir_q   <= 1'b0;
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			size_q  <= '0;
			slice_q <= '0;
		end else if (take) begin
			main_q  <= main_d;
			aux_q   <= aux_d;
			cnt_q   <= cnt_d;
			dir_q   <= dir_d;
			busy_q  <= busy_d;
			pend_q  <= pend_d;
			size_q  <= size_d;
			slice_q <= slice_d;
		end
	end

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(main_q[4:0] == '0) && (aux_q[4:0] == '0) && (cnt_q[4:0] == '0))
		else $error("address or count lost burst alignment");
	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && ((kind == XK_M2A) || (kind == XK_A2M)) |->
			busy_q && (xl == LEN_W'(BURST_BYTES)))
		else $error("burst command outside a running transfer");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> (cnt_q != '0) && (slice_q != '0))
		else $error("transfer started with empty count or slice");

endmodule

>>> rtl/amdc_outq.sv
// Result queue: holds finished result words until the consumer pops them.
module amdc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_push,
	input  amdc_pkg::result_t   res_in,
	output logic                res_full,
	output logic                empty,
	input  logic                pop,
	output amdc_pkg::result_t   rsp
);
	import amdc_pkg::*;

	result_t           fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign res_full = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign rsp      = fifo_q[rd_ptr_q];

	// Store the result word
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= res_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_outq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue over depth");
	a_outq_push: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

endmodule

>>> rtl/aux_memory_dma_controller.sv
// Top level of the aux memory DMA controller: front end, back end and result queue.
//
//   channel   dir  handshake         word
//   request   in   push / full       req  (req_type, reg_sel, wdata)
//   result    out  empty / pop       rsp  (rdata, xfer_*, busy_res, int_flag, irq)
//   config    in   cfg_we            cfg_idx, cfg_wdata (0 int_mask, 1 slice_ticks)
//
// One request word per cycle while pop keeps up; every word yields exactly one result word.
// A result reaches rsp via the front queue, then the result queue that the back end writes.
// The back end logic per word is combinational: masks, three parallel 26-bit adds or subtracts, compares.
// Reset sets all but queue storage at once (slice_ticks to 1, else 0); no clearing pass is needed.
// With pop low the result queue fills, the back end stops and full rises after two more words.
module aux_memory_dma_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  amdc_pkg::in_item_t  req,
	output logic                empty,
	input  logic                pop,
	output amdc_pkg::result_t   rsp,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_wdata
);
	import amdc_pkg::*;

	logic    cmd_valid;
	cmd_t    cmd;
	logic    take;
	logic    res_full;
	logic    res_push;
	result_t res_in;

	amdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.take      (take),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	amdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.take      (take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_in    (res_in)
	);

	amdc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

>>> tb/sv/tb.sv
// Testbench of the aux memory DMA controller: directed and random words checked by a predictor.
module tb;
	import amdc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;
	// Selectors past the refresh register decode to nothing
	localparam logic [SEL_W-1:0] SEL_SPARE_LO = 4'd12;
	localparam logic [SEL_W-1:0] SEL_SPARE_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t req = '0;
	logic empty;
	logic pop = 1'b0;
	result_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// Predicted controller state and register copies
	logic cfg_mask = 1'b0;
	logic [TICK_W-1:0] cfg_slice = 16'd1;
	logic [ADDR_W-1:0] dma_main = '0;
	logic [ADDR_W-1:0] dma_aux = '0;
	logic [ADDR_W-1:0] dma_count = '0;
	logic dma_dir = 1'b0;
	logic dma_busy = 1'b0;
	logic dma_int = 1'b0;
	logic [SIZE_W-1:0] dma_size = '0;
	logic [TICK_W-1:0] dma_slice_left = '0;

	result_t rsp_due[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int rsp_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	int kind_seen[5] = '{default: 0};

	aux_memory_dma_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic in_item_t req_word(input logic [REQ_W-1:0] kind,
			input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] d);
		in_item_t w;
		w.req_type = kind;
		w.reg_sel = sel;
		w.wdata = d;
		return w;
	endfunction

	function automatic logic [TICK_W-1:0] slice_period();
		return (cfg_slice == '0) ? 16'd1 : cfg_slice;
	endfunction

	// Kick off a transfer from the current address and count registers
	function automatic void start_xfer(inout result_t r);
		if (!dma_busy) begin
			if (dma_main == BOOT_MAIN && dma_aux == '0) begin
				r.xfer_kind = XK_BOOT;
				r.xfer_main_addr = dma_main;
				r.xfer_aram_addr = '0;
				r.xfer_len = {dma_count, 2'b00};
				dma_count = '0;
				dma_int = 1'b1;
			end else if (dma_aux >= AUX_BYTES) begin
				// aux reads past the end become a zero fill, writes are dropped
				if (dma_dir) begin
					r.xfer_kind = XK_ZFILL;
					r.xfer_main_addr = dma_main;
					r.xfer_aram_addr = dma_aux;
					r.xfer_len = {2'b00, dma_count};
					dma_count = '0;
					dma_int = 1'b1;
				end
			end else if (dma_count == '0) begin
				dma_int = 1'b1;
			end else begin
				dma_busy = 1'b1;
				dma_slice_left = slice_period();
			end
		end
	endfunction

	// Advance the predicted state by one request word and return its result word
	function automatic result_t dma_step(input in_item_t w);
		result_t r;
		logic [DATA_W-1:0] d;
		r = '0;
		d = w.wdata;
		case (w.req_type)
			REQ_WRITE: begin
				case (w.reg_sel)
					SEL_MAIN_HI: dma_main = {d[9:0], dma_main[15:0]};
					SEL_MAIN_LO: dma_main = {dma_main[25:16], d[15:5], 5'b0};
					SEL_AUX_HI: dma_aux = {d[9:0], dma_aux[15:0]};
					SEL_AUX_LO: dma_aux = {dma_aux[25:16], d[15:5], 5'b0};
					SEL_COUNT_HI: begin
						dma_dir = d[15];
						dma_count = {d[9:0], dma_count[15:0]};
					end
					SEL_COUNT_LO: begin
						dma_count = {dma_count[25:16], d[15:5], 5'b0};
						start_xfer(r);
					end
					SEL_MAIN_W: dma_main = {d[25:5], 5'b0};
					SEL_AUX_W: dma_aux = {d[25:5], 5'b0};
					SEL_COUNT_W: begin
						dma_dir = d[31];
						dma_count = {d[25:5], 5'b0};
						start_xfer(r);
					end
					SEL_SIZE: dma_size = d[15:0];
					default: ;
				endcase
			end
			REQ_READ: begin
				case (w.reg_sel)
					SEL_MAIN_HI: r.rdata = {22'b0, dma_main[25:16]};
					SEL_MAIN_LO: r.rdata = {16'b0, dma_main[15:5], 5'b0};
					SEL_AUX_HI: r.rdata = {22'b0, dma_aux[25:16]};
					SEL_AUX_LO: r.rdata = {16'b0, dma_aux[15:5], 5'b0};
					SEL_COUNT_HI: r.rdata = {16'b0, dma_dir, 5'b0, dma_count[25:16]};
					SEL_COUNT_LO: r.rdata = {16'b0, dma_count[15:5], 5'b0};
					SEL_MAIN_W: r.rdata = {6'b0, dma_main};
					SEL_AUX_W: r.rdata = {6'b0, dma_aux};
					SEL_COUNT_W: r.rdata = {dma_dir, 5'b0, dma_count};
					SEL_SIZE: r.rdata = {16'b0, dma_size};
					SEL_MODE: r.rdata = 32'd1;
					default: r.rdata = '0;
				endcase
			end
			REQ_TICK: begin
				if (dma_busy) begin
					if (dma_slice_left > 16'd1) begin
						dma_slice_left--;
					end else begin
						dma_slice_left = slice_period();
						if (dma_count != '0) begin
							r.xfer_kind = dma_dir ? XK_A2M : XK_M2A;
							r.xfer_main_addr = dma_main;
							r.xfer_aram_addr = dma_aux;
							r.xfer_len = LEN_W'(BURST_BYTES);
							dma_main = dma_main + ADDR_W'(BURST_BYTES);
							dma_aux = dma_aux + ADDR_W'(BURST_BYTES);
							dma_count = dma_count - ADDR_W'(BURST_BYTES);
						end
						if (dma_count == '0) begin
							dma_busy = 1'b0;
							dma_int = 1'b1;
						end
					end
				end
			end
			REQ_CLEAR: dma_int = 1'b0;
			default: ;
		endcase
		r.busy_res = dma_busy;
		r.int_flag = dma_int;
		r.irq = dma_int & cfg_mask;
		return r;
	endfunction

	// Offer one request word, idling first at the phase's rate; return at a falling edge
	task automatic send_word(input in_item_t w);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		req <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		rsp_due.push_back(dma_step(w));
		words_sent++;
		@(negedge clk);
	endtask

	// Hold off requests until every predicted result word has come back
	task automatic settle();
		push <= 1'b0;
		@(negedge clk);
		while (rsp_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INT_MASK)
			cfg_mask = val[0];
		else
			cfg_slice = val;
		@(negedge clk);
	endtask

	// Register writes and reads at the field extremes, plus the decode corners
	task automatic test_register_file();
		send_word(req_word(REQ_WRITE, SEL_MAIN_W, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_MAIN_W, 32'h0));
		send_word(req_word(REQ_READ, SEL_MAIN_HI, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_MAIN_LO, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_AUX_HI, 32'hFFFF_FFFF));
		send_word(req_word(REQ_WRITE, SEL_AUX_LO, 32'h0));
		send_word(req_word(REQ_READ, SEL_AUX_W, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_SIZE, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_SIZE, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_MODE, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_MODE, 32'h0));
		send_word(req_word(REQ_READ, SEL_REFRESH, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_SPARE_HI, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_SPARE_LO, 32'h0));
	endtask

	// Zero fill, dropped aux write, boot load, empty count, wrap and a count write while busy
	task automatic test_transfer_cases();
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h8000_0040));
		send_word(req_word(REQ_CLEAR, SEL_SPARE_HI, 32'hFFFF_FFFF));
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h0000_0040));
		send_word(req_word(REQ_READ, SEL_COUNT_W, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_MAIN_W, 32'h0100_0000));
		send_word(req_word(REQ_WRITE, SEL_AUX_W, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'hFFFF_FFFF));
		send_word(req_word(REQ_READ, SEL_COUNT_HI, 32'h0));
		send_word(req_word(REQ_CLEAR, SEL_MAIN_HI, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_AUX_W, 32'h0000_0100));
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h0));
		// main address wraps past the top during this one
		send_word(req_word(REQ_WRITE, SEL_MAIN_W, 32'hFFFF_FFE0));
		send_word(req_word(REQ_WRITE, SEL_COUNT_HI, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_COUNT_LO, 32'h0000_0040));
		send_word(req_word(REQ_TICK, SEL_MAIN_HI, 32'h0));
		send_word(req_word(REQ_TICK, SEL_MAIN_HI, 32'h0));
		send_word(req_word(REQ_READ, SEL_MAIN_W, 32'h0));
		// start another transfer, then write a zero count while busy to drop it mid-transfer
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h8000_0060));
		send_word(req_word(REQ_TICK, SEL_MAIN_HI, 32'h0));
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h0));
		send_word(req_word(REQ_TICK, SEL_MAIN_HI, 32'h0));
		send_word(req_word(REQ_TICK, SEL_MAIN_HI, 32'h0));
	endtask

	// One burst at a long slice length: the tick counter runs down from 100
	task automatic test_long_slice();
		settle();
		write_cfg(CFG_SLICE_TICKS, 16'd100);
		idle_pct = 0;
		stall_pct = 0;
		send_word(req_word(REQ_WRITE, SEL_AUX_W, 32'h0000_0400));
		send_word(req_word(REQ_WRITE, SEL_COUNT_W, 32'h0000_0020));
		repeat (100)
			send_word(req_word(REQ_TICK, SEL_SPARE_LO, 32'h0));
		send_word(req_word(REQ_READ, SEL_COUNT_W, 32'h0));
	endtask

	// Mostly complete transfer setups with random content, some noise words in between
	task automatic test_random_traffic(input int idle, input int stall, input logic mask,
			input logic [15:0] slice, input int n_words);
		logic [ADDR_W-1:0] main_a;
		logic [ADDR_W-1:0] aux_a;
		logic [ADDR_W-1:0] count_a;
		logic [DATA_W-1:0] r;
		logic dir;
		int stop_at;
		int guard;
		bit paused;
		settle();
		write_cfg(CFG_INT_MASK, {15'b0, mask});
		write_cfg(CFG_SLICE_TICKS, slice);
		idle_pct = idle;
		stall_pct = stall;
		paused = 1'b0;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(4) == 0) begin
				send_word(req_word(REQ_W'($urandom), SEL_W'($urandom), $urandom));
			end else begin
				// pick the addresses: boot, near the top, out of aux range or anywhere
				case ($urandom_range(9))
					0: main_a = BOOT_MAIN;
					1: main_a = ADDR_W'(26'h3FF_FFE0 - $urandom_range(3) * BURST_BYTES);
					default: main_a = ADDR_W'($urandom);
				endcase
				case ($urandom_range(9))
					0: aux_a = '0;
					1: aux_a = ADDR_W'($urandom) | 26'h100_0000;
					2: aux_a = ADDR_W'(26'h0FF_FFE0 - $urandom_range(3) * BURST_BYTES);
					default: aux_a = ADDR_W'($urandom_range(24'hFF_FFFF));
				endcase
				main_a[4:0] = '0;
				aux_a[4:0] = '0;
				count_a = ADDR_W'($urandom_range(6) * BURST_BYTES);
				dir = 1'($urandom);
				if ($urandom_range(1)) begin
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_MAIN_HI, {r[31:10], main_a[25:16]}));
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_MAIN_LO, {r[31:16], main_a[15:5], r[4:0]}));
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_AUX_HI, {r[31:10], aux_a[25:16]}));
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_AUX_LO, {r[31:16], aux_a[15:5], r[4:0]}));
				end else begin
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_MAIN_W, {r[31:26], main_a[25:5], r[4:0]}));
					r = $urandom;
					send_word(req_word(REQ_WRITE, SEL_AUX_W, {r[31:26], aux_a[25:5], r[4:0]}));
				end
				if ($urandom_range(1)) begin
					r = $urandom;
					r[15] = dir;
					r[9:0] = count_a[25:16];
					send_word(req_word(REQ_WRITE, SEL_COUNT_HI, r));
					r = $urandom;
					r[15:5] = count_a[15:5];
					send_word(req_word(REQ_WRITE, SEL_COUNT_LO, r));
				end else begin
					r = $urandom;
					r[31] = dir;
					r[25:5] = count_a[25:5];
					send_word(req_word(REQ_WRITE, SEL_COUNT_W, r));
				end
				// run the transfer out with reads, clears and restarts mixed in
				guard = 0;
				while (dma_busy && guard < 80) begin
					case ($urandom_range(19))
						0, 1, 2: send_word(req_word(REQ_READ, SEL_W'($urandom), $urandom));
						3: send_word(req_word(REQ_CLEAR, SEL_W'($urandom), $urandom));
						4: begin
							r = $urandom;
							r[25:5] = 21'($urandom_range(3));
							send_word(req_word(REQ_WRITE, SEL_COUNT_W, r));
						end
						5: send_word(req_word(REQ_WRITE, SEL_SIZE, $urandom));
						default: send_word(req_word(REQ_TICK, SEL_W'($urandom), $urandom));
					endcase
					guard++;
				end
				if ($urandom_range(1))
					send_word(req_word(REQ_READ, SEL_COUNT_W, $urandom));
				if ($urandom_range(1))
					send_word(req_word(REQ_CLEAR, SEL_W'($urandom), $urandom));
			end
			// drain once halfway through the phase
			if (!paused && words_sent >= stop_at - n_words / 2) begin
				settle();
				paused = 1'b1;
			end
		end
	endtask

	// Randomize pop at the phase's stall rate
	always @(negedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : rsp_check
		result_t want;
		if (arst_n && pop && !empty) begin
			rsp_seen++;
			if (rsp.xfer_kind <= XK_BOOT)
				kind_seen[rsp.xfer_kind]++;
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result word with nothing outstanding: %p", rsp);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.rdata !== want.rdata || rsp.xfer_kind !== want.xfer_kind
						|| rsp.xfer_main_addr !== want.xfer_main_addr
						|| rsp.xfer_aram_addr !== want.xfer_aram_addr
						|| rsp.xfer_len !== want.xfer_len || rsp.busy_res !== want.busy_res
						|| rsp.int_flag !== want.int_flag || rsp.irq !== want.irq) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display({"ERROR: result %0d expected rdata %h kind %0d main %h",
							" aram %h len %h busy %b int %b irq %b"},
							rsp_seen, want.rdata, want.xfer_kind, want.xfer_main_addr,
							want.xfer_aram_addr, want.xfer_len, want.busy_res, want.int_flag,
							want.irq);
						$display({"       result %0d actual   rdata %h kind %0d main %h",
							" aram %h len %h busy %b int %b irq %b"},
							rsp_seen, rsp.rdata, rsp.xfer_kind, rsp.xfer_main_addr,
							rsp.xfer_aram_addr, rsp.xfer_len, rsp.busy_res, rsp.int_flag,
							rsp.irq);
					end
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ERROR: run exceeded %0d cycles with %0d result words outstanding",
				CYCLE_LIMIT, rsp_due.size());
			$display("FAIL aux_memory_dma_controller");
			$finish;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_cfg(CFG_INT_MASK, 16'd1);
		write_cfg(CFG_SLICE_TICKS, 16'd1);
		test_register_file();
		test_transfer_cases();
		test_long_slice();
		test_random_traffic(0, 0, 1'b1, 16'd0, 220);
		test_random_traffic(88, 0, 1'b0, 16'd2, 220);
		test_random_traffic(0, 88, 1'b1, 16'd3, 220);
		test_random_traffic(34, 34, 1'b1, 16'd1, 220);
		test_random_traffic(0, 0, 1'b0, 16'd4, 220);
		settle();
		repeat (8) @(negedge clk);
		$display("Sent %0d request words, checked %0d result words, %0d mismatching.",
			words_sent, rsp_seen, mismatches);
		$display({"Saw %0d bursts to aux, %0d to main, %0d zero fills, %0d boot loads;",
			" slices 0 to 100, irq mask on and off."},
			kind_seen[XK_M2A], kind_seen[XK_A2M], kind_seen[XK_ZFILL], kind_seen[XK_BOOT]);
		if (mismatches == 0)
			$display("PASS aux_memory_dma_controller");
		else
			$display("FAIL aux_memory_dma_controller");
		$finish;
	end

endmodule
